[rtl/lrub_pkg.sv]
// lrub_pkg: shared widths, operation codes and types for the lru byte-budget unit
// no dependencies; imported by every rtl file of the block

package lrub_pkg;

    localparam int LRUB_ENTRIES = 16;

    localparam int FUNC_W = 2;
    localparam int SLOT_W = 4;
    localparam int BYTE_W = 31;

    localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_EJECT  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] sum;
        logic              more;
    } t_acc_res;

endpackage

[rtl/lrub_sat_acc.sv]
// lrub_sat_acc: saturating byte accumulator with compare against the eject target
// depends on lrub_pkg

module lrub_sat_acc
    import lrub_pkg::*;
(
    input  logic [BYTE_W-1:0] i_total,
    input  logic [BYTE_W-1:0] i_size,
    input  logic [BYTE_W-1:0] i_target,
    output t_acc_res          o_res
);

    logic [BYTE_W:0]   raw_sum;
    logic [BYTE_W-1:0] sat_sum;

    assign raw_sum    = {1'b0, i_total} + {1'b0, i_size};
    assign sat_sum    = raw_sum[BYTE_W] ? BYTE_MAX : raw_sum[BYTE_W-1:0];
    assign o_res.sum  = sat_sum;
    assign o_res.more = sat_sum < i_target;

endmodule

[rtl/lru_order_with_byte_budget_eviction_unit.sv]
// channel   | valid / ready            | payload
// request   | i_in_valid / o_in_ready  | i_func, i_slot, i_byte_count
// result    | o_out_valid / i_out_ready| o_evicted, o_evicted_slot, o_evicted_bytes,
//           |                          | o_freed_total, o_status, o_last
//
// insert and rejected requests: the idle state, then the emit state writes the result register
// touch and remove: one rank lookup pass and one rank shift pass, then the emit state
// eject: per ejected slot, one scan of the rank table, an accumulate step and an emit step
// a full result register stalls the sequencer before it writes the next result
// synchronous active-low reset empties the order; no clearing pass is needed
// depends on lrub_pkg and lrub_sat_acc

module lru_order_with_byte_budget_eviction_unit
    import lrub_pkg::*;
#(
    parameter int ENTRIES = LRUB_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [BYTE_W-1:0] i_byte_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_evicted,
    output logic [SLOT_W-1:0] o_evicted_slot,
    output logic [BYTE_W-1:0] o_evicted_bytes,
    output logic [BYTE_W-1:0] o_freed_total,
    output logic              o_status,
    output logic              o_last
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [SW-1:0] IDX_LAST = SW'(ENTRIES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIND  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_EJECT = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]        r_state;
    logic [SW-1:0]     r_idx;
    logic [ENTRIES-1:0] r_valid;
    logic [SW-1:0]     r_rank [ENTRIES];
    logic [BYTE_W-1:0] r_size_mem [ENTRIES];
    logic [CW-1:0]     r_count;
    logic [FUNC_W-1:0] r_op;
    logic [SW-1:0]     r_sidx;
    logic [SW-1:0]     r_ref;
    logic [BYTE_W-1:0] r_target;
    logic [BYTE_W-1:0] r_total;
    logic [SW-1:0]     r_victim;
    logic [BYTE_W-1:0] r_vsize;

    logic              r_pend_evicted;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [BYTE_W-1:0] r_pend_bytes;
    logic [BYTE_W-1:0] r_pend_total;
    logic              r_pend_status;
    logic              r_pend_last;

    logic              r_out_valid;
    logic              r_out_evicted;
    logic [SLOT_W-1:0] r_out_slot;
    logic [BYTE_W-1:0] r_out_bytes;
    logic [BYTE_W-1:0] r_out_total;
    logic              r_out_status;
    logic              r_out_last;

    logic          in_acc;
    logic [SW-1:0] s_idx;
    logic          s_inr;
    logic          ins_ok;
    logic          out_free;
    logic          scan_last;
    logic [SW-1:0] cur_rank;
    logic          cur_valid;
    logic          victim_hit;
    t_acc_res      acc_res;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign s_idx      = SW'(i_slot);
    assign s_inr      = int'(i_slot) < ENTRIES;
    assign ins_ok     = in_acc && (i_func == FUNC_INSERT) && s_inr && !r_valid[s_idx];
    assign out_free   = !r_out_valid || i_out_ready;
    assign scan_last  = (r_idx == IDX_LAST);
    assign cur_rank   = r_rank[r_idx];
    assign cur_valid  = r_valid[r_idx];
    assign victim_hit = (r_state == ST_EJECT) && cur_valid && (cur_rank == '0);

    lrub_sat_acc u_acc (
        .i_total  (r_total),
        .i_size   (r_vsize),
        .i_target (r_target),
        .o_res    (acc_res)
    );

    // size store
    always_ff @(posedge i_clk) begin
        if (ins_ok) begin
            r_size_mem[s_idx] <= i_byte_count;
        end
        if (victim_hit) begin
            r_vsize <= r_size_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_out_ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op           <= i_func;
                        r_sidx         <= s_idx;
                        r_target       <= i_byte_count;
                        r_total        <= '0;
                        r_idx          <= '0;
                        r_pend_evicted <= 1'b0;
                        r_pend_slot    <= '0;
                        r_pend_bytes   <= '0;
                        r_pend_total   <= '0;
                        r_pend_status  <= 1'b0;
                        r_pend_last    <= 1'b1;
                        case (i_func)
                            FUNC_INSERT: begin
                                if (ins_ok) begin
                                    r_valid[s_idx] <= 1'b1;
                                    r_rank[s_idx]  <= SW'(r_count);
                                    r_count        <= r_count + CW'(1);
                                end else begin
                                    r_pend_status <= 1'b1;
                                end
                                r_state <= ST_EMIT;
                            end
                            FUNC_TOUCH, FUNC_REMOVE: begin
                                if (!s_inr || !r_valid[s_idx]) begin
                                    r_pend_status <= 1'b1;
                                    r_state       <= ST_EMIT;
                                end else begin
                                    r_state <= ST_FIND;
                                end
                            end
                            default: begin
                                if (i_byte_count == '0 || r_count == '0) begin
                                    r_state <= ST_EMIT;
                                end else begin
                                    r_state <= ST_EJECT;
                                end
                            end
                        endcase
                    end
                end
                ST_FIND: begin
                    if (r_idx == r_sidx) begin
                        r_ref <= cur_rank;
                    end
                    if (scan_last) begin
                        r_idx   <= '0;
                        r_state <= ST_SHIFT;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                ST_SHIFT: begin
                    if (r_idx == r_sidx) begin
                        if (r_op == FUNC_TOUCH) begin
                            r_rank[r_idx] <= SW'(r_count - CW'(1));
                        end else begin
                            r_valid[r_idx] <= 1'b0;
                            r_rank[r_idx]  <= '0;
                        end
                    end else if (cur_valid && cur_rank > r_ref) begin
                        r_rank[r_idx] <= cur_rank - SW'(1);
                    end
                    if (scan_last) begin
                        if (r_op == FUNC_REMOVE) begin
                            r_count <= r_count - CW'(1);
                        end
                        r_idx   <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                ST_EJECT: begin
                    if (victim_hit) begin
                        r_valid[r_idx] <= 1'b0;
                        r_rank[r_idx]  <= '0;
                        r_victim       <= r_idx;
                    end else if (cur_valid) begin
                        r_rank[r_idx] <= cur_rank - SW'(1);
                    end
                    if (scan_last) begin
                        r_idx   <= '0;
                        r_state <= ST_ACC;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                ST_ACC: begin
                    r_total        <= acc_res.sum;
                    r_count        <= r_count - CW'(1);
                    r_pend_evicted <= 1'b1;
                    r_pend_slot    <= SLOT_W'(r_victim);
                    r_pend_bytes   <= r_vsize;
                    r_pend_total   <= acc_res.sum;
                    r_pend_status  <= 1'b0;
                    r_pend_last    <= !(acc_res.more && r_count > CW'(1));
                    r_state        <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_evicted <= r_pend_evicted;
                        r_out_slot    <= r_pend_slot;
                        r_out_bytes   <= r_pend_bytes;
                        r_out_total   <= r_pend_total;
                        r_out_status  <= r_pend_status;
                        r_out_last    <= r_pend_last;
                        r_state       <= r_pend_last ? ST_IDLE : ST_EJECT;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_evicted       = r_out_evicted;
    assign o_evicted_slot  = r_out_slot;
    assign o_evicted_bytes = r_out_bytes;
    assign o_freed_total   = r_out_total;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

endmodule

[rtl/lrub_checker.sv]
// lrub_checker: port-level checks on the lru byte-budget unit, bound to the top level
// depends on lrub_pkg and lru_order_with_byte_budget_eviction_unit

module lrub_checker
    import lrub_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_evicted,
    input logic [SLOT_W-1:0] o_evicted_slot,
    input logic [BYTE_W-1:0] o_evicted_bytes,
    input logic [BYTE_W-1:0] o_freed_total,
    input logic              o_status,
    input logic              o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_evicted_slot)
            && $stable(o_freed_total) && $stable(o_last))
        else $error("stalled result changed");

    // the unit is not ready in the cycle after it accepts a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a request");

    // a result without an ejected slot is a single, final, empty one
    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> o_last && o_evicted_slot == '0
            && o_evicted_bytes == '0 && o_freed_total == '0)
        else $error("bad non-eject result");

    // ejected slots report ok and a total covering their own size
    a_eject_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> !o_status && o_freed_total >= o_evicted_bytes)
        else $error("bad eject result");

endmodule

bind lru_order_with_byte_budget_eviction_unit lrub_checker u_lrub_checker (.*);
